[hw/rtl/bpc_pkg.sv]
// shared widths, constants and pipeline sideband type for the barycentric classifier
// no dependencies
package bpc_pkg;
   localparam int CW  = 16;          // input coordinate width, Q12.4
   localparam int VW  = CW + 1;      // edge vector component
   localparam int XW  = 2 * VW;      // product and cross product, signed
   localparam int MW  = XW - 1;      // cross product magnitude
   localparam int FW  = 16;          // fraction bits of the weights
   localparam int QW  = MW + FW;     // quotient magnitude
   localparam int RW  = MW + 1;      // divider remainder
   localparam int SW  = QW + 2;      // signed quotient and alpha
   localparam int WW  = 20;          // weight width, Q3.16
   localparam int TW  = 32;          // degenerate threshold width
   localparam int ZW  = 16;          // zero tolerance width
   localparam int SQW = 34;          // square of a small denominator
   localparam int SMW = 18;          // signed width of a small denominator

   localparam logic [MW-1:0] SMALL_MAX = MW'(65536);
   localparam logic signed [SW-1:0] ONE_Q16 = SW'(65536);
   localparam logic signed [SW-1:0] W_MAX = SW'(524287);
   localparam logic signed [SW-1:0] W_MIN = -SW'(524288);

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_TOLERANCE = 1'b1;

   typedef struct packed {
      logic           neg_b;
      logic           neg_g;
      logic           is_small;
      logic [SQW-1:0] sq;
   } side_type;
endpackage

[hw/rtl/bpc_front.sv]
// front stages: edge vectors, products, cross products, magnitudes and signs
// depends on bpc_pkg
module bpc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [bpc_pkg::CW-1:0] px,
   input  logic signed [bpc_pkg::CW-1:0] py,
   input  logic signed [bpc_pkg::CW-1:0] ax,
   input  logic signed [bpc_pkg::CW-1:0] ay,
   input  logic signed [bpc_pkg::CW-1:0] bx,
   input  logic signed [bpc_pkg::CW-1:0] by,
   input  logic signed [bpc_pkg::CW-1:0] cx,
   input  logic signed [bpc_pkg::CW-1:0] cy,
   output logic                        out_valid,
   output logic [bpc_pkg::MW-1:0]      mag_d,
   output logic [bpc_pkg::MW-1:0]      mag_b,
   output logic [bpc_pkg::MW-1:0]      mag_g,
   output bpc_pkg::side_type           side
);
   import bpc_pkg::*;

   logic [3:0] valid_ff;
   logic signed [VW-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [XW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [XW-1:0] d_ff, nb_ff, ng_ff;
   logic [MW-1:0] mag_d_ff, mag_b_ff, mag_g_ff;
   side_type side_ff;
   logic [XW-1:0] abs_d, abs_b, abs_g;
   logic signed [2*SMW-1:0] sq_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_comb begin
      abs_d = d_ff[XW-1] ? XW'(-d_ff) : XW'(d_ff);
      abs_b = nb_ff[XW-1] ? XW'(-nb_ff) : XW'(nb_ff);
      abs_g = ng_ff[XW-1] ? XW'(-ng_ff) : XW'(ng_ff);
      sq_full = $signed(d_ff[SMW-1:0]) * $signed(d_ff[SMW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v0x_ff <= VW'(bx) - VW'(ax);
         v0y_ff <= VW'(by) - VW'(ay);
         v1x_ff <= VW'(cx) - VW'(ax);
         v1y_ff <= VW'(cy) - VW'(ay);
         v2x_ff <= VW'(px) - VW'(ax);
         v2y_ff <= VW'(py) - VW'(ay);
         p0_ff <= v0x_ff * v1y_ff;
         p1_ff <= v0y_ff * v1x_ff;
         p2_ff <= v2x_ff * v1y_ff;
         p3_ff <= v2y_ff * v1x_ff;
         p4_ff <= v0x_ff * v2y_ff;
         p5_ff <= v0y_ff * v2x_ff;
         d_ff  <= p0_ff - p1_ff;
         nb_ff <= p2_ff - p3_ff;
         ng_ff <= p4_ff - p5_ff;
         mag_d_ff <= abs_d[MW-1:0];
         mag_b_ff <= abs_b[MW-1:0];
         mag_g_ff <= abs_g[MW-1:0];
         side_ff.neg_b <= nb_ff[XW-1] ^ d_ff[XW-1];
         side_ff.neg_g <= ng_ff[XW-1] ^ d_ff[XW-1];
         side_ff.is_small <= abs_d[MW-1:0] <= SMALL_MAX;
         side_ff.sq    <= sq_full[SQW-1:0];
      end
   end

   assign out_valid = valid_ff[3];
   assign mag_d = mag_d_ff;
   assign mag_b = mag_b_ff;
   assign mag_g = mag_g_ff;
   assign side = side_ff;
endmodule

[hw/rtl/bpc_div.sv]
// pipelined restoring divider, one quotient bit per stage, two lanes on one divisor
// depends on bpc_pkg
module bpc_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [bpc_pkg::MW-1:0]  den,
   input  logic [bpc_pkg::MW-1:0]  num_b,
   input  logic [bpc_pkg::MW-1:0]  num_g,
   input  bpc_pkg::side_type       side_in,
   output logic                    out_valid,
   output logic [bpc_pkg::QW-1:0]  quo_b,
   output logic [bpc_pkg::QW-1:0]  quo_g,
   output bpc_pkg::side_type       side_out
);
   import bpc_pkg::*;

   localparam int AW = RW + QW;

   logic [QW-1:0] valid_ff;
   logic [AW-1:0] acc_b_ff [QW];
   logic [AW-1:0] acc_g_ff [QW];
   logic [MW-1:0] den_ff [QW];
   side_type      side_ff [QW];

   function automatic logic [AW-1:0] div_step(input logic [AW-1:0] a, input logic [MW-1:0] d);
      logic [AW-1:0] s;
      logic [RW-1:0] part;
      s = a << 1;
      part = s[AW-1:QW];
      if (part >= {1'b0, d}) begin
         s[AW-1:QW] = part - {1'b0, d};
         s[0] = 1'b1;
      end
      return s;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               acc_b_ff[k] <= div_step({{RW{1'b0}}, num_b, {FW{1'b0}}}, den);
               acc_g_ff[k] <= div_step({{RW{1'b0}}, num_g, {FW{1'b0}}}, den);
               den_ff[k]   <= den;
               side_ff[k]  <= side_in;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               acc_b_ff[k] <= div_step(acc_b_ff[k-1], den_ff[k-1]);
               acc_g_ff[k] <= div_step(acc_g_ff[k-1], den_ff[k-1]);
               den_ff[k]   <= den_ff[k-1];
               side_ff[k]  <= side_ff[k-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quo_b = acc_b_ff[QW-1][QW-1:0];
   assign quo_g = acc_g_ff[QW-1][QW-1:0];
   assign side_out = side_ff[QW-1];
endmodule

[hw/rtl/bpc_back.sv]
// back stages: signs, alpha, degenerate test, saturation and classification flags
// depends on bpc_pkg
module bpc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [bpc_pkg::QW-1:0]      quo_b,
   input  logic [bpc_pkg::QW-1:0]      quo_g,
   input  bpc_pkg::side_type           side,
   input  logic [bpc_pkg::TW-1:0]      threshold,
   input  logic [bpc_pkg::ZW-1:0]      tolerance,
   output logic                        out_valid,
   output logic signed [bpc_pkg::WW-1:0] alpha,
   output logic signed [bpc_pkg::WW-1:0] beta,
   output logic signed [bpc_pkg::WW-1:0] gamma,
   output logic                        degen,
   output logic                        in_tri,
   output logic                        edge_hit,
   output logic                        vertex_hit,
   output logic                        clipped
);
   import bpc_pkg::*;

   logic [2:0] valid_ff;
   logic signed [SW-1:0] qa_ff, qb_ff, qg_ff;
   logic degen1_ff, degen2_ff, clip2_ff;
   logic signed [WW-1:0] wa2_ff, wb2_ff, wg2_ff;
   logic signed [WW-1:0] wa_ff, wb_ff, wg_ff;
   logic degen_ff, inside_ff, edge_ff, vert_ff, clip_ff;
   logic signed [SW-1:0] qb_in, qg_in;
   logic signed [WW-1:0] wa_in, wb_in, wg_in;
   logic ca, cb, cg;
   logic za, zb, zg, oa, ob, og, in_in;

   function automatic logic signed [WW-1:0] sat(input logic signed [SW-1:0] v, output logic c);
      c = 1'b1;
      if (v > W_MAX) return WW'(W_MAX);
      if (v < W_MIN) return WW'(W_MIN);
      c = 1'b0;
      return v[WW-1:0];
   endfunction

   function automatic logic near(input logic signed [WW-1:0] w, input logic one,
                                 input logic [ZW-1:0] tol);
      logic signed [WW+1:0] d;
      logic [WW+1:0] m;
      d = (WW+2)'(w) - (one ? (WW+2)'(65536) : (WW+2)'(0));
      m = d[WW+1] ? (WW+2)'(-d) : (WW+2)'(d);
      return m <= (WW+2)'(tol);
   endfunction

   always_comb begin
      qb_in = side.neg_b ? -SW'(quo_b) : SW'(quo_b);
      qg_in = side.neg_g ? -SW'(quo_g) : SW'(quo_g);
      wa_in = sat(qa_ff, ca);
      wb_in = sat(qb_ff, cb);
      wg_in = sat(qg_ff, cg);
      za = near(wa2_ff, 1'b0, tolerance);
      zb = near(wb2_ff, 1'b0, tolerance);
      zg = near(wg2_ff, 1'b0, tolerance);
      oa = near(wa2_ff, 1'b1, tolerance);
      ob = near(wb2_ff, 1'b1, tolerance);
      og = near(wg2_ff, 1'b1, tolerance);
      in_in = !wa2_ff[WW-1] && !wb2_ff[WW-1] && !wg2_ff[WW-1] && !degen2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qb_ff <= qb_in;
         qg_ff <= qg_in;
         qa_ff <= ONE_Q16 - qb_in - qg_in;
         degen1_ff <= side.is_small && (SQW'(side.sq) <= SQW'(threshold));
         degen2_ff <= degen1_ff;
         wa2_ff <= degen1_ff ? '0 : wa_in;
         wb2_ff <= degen1_ff ? '0 : wb_in;
         wg2_ff <= degen1_ff ? '0 : wg_in;
         clip2_ff <= !degen1_ff && (ca || cb || cg);
         wa_ff <= wa2_ff;
         wb_ff <= wb2_ff;
         wg_ff <= wg2_ff;
         degen_ff <= degen2_ff;
         clip_ff <= clip2_ff;
         inside_ff <= in_in;
         edge_ff <= in_in && (za || zb || zg);
         vert_ff <= !degen2_ff && ((oa && zb && zg) || (ob && za && zg) || (og && za && zb));
      end
   end

   assign out_valid = valid_ff[2];
   assign alpha = wa_ff;
   assign beta = wb_ff;
   assign gamma = wg_ff;
   assign degen = degen_ff;
   assign in_tri = inside_ff;
   assign edge_hit = edge_ff;
   assign vertex_hit = vert_ff;
   assign clipped = clip_ff;
endmodule

[hw/rtl/barycentric_point_classifier.sv]
// top level of the barycentric point classifier: csr registers and pipeline control
// depends on bpc_pkg, bpc_front, bpc_div, bpc_back
//
//   channel  dir  handshake          payload
//   req      in   req_valid/ready    point and three vertices, Q12.4
//   rsp      out  rsp_valid/ready    three Q3.16 weights and five flags
//   csr      in   csr_we             csr_index, csr_wdata
//
// one request per cycle sustained while responses are accepted; 4 front stages,
// 49 divider stages (one quotient bit each) and 3 back stages
// the whole pipeline holds while a response waits and rsp_ready is low
// synchronous reset clears valid bits and csr registers
module barycentric_point_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [bpc_pkg::CW-1:0] req_point_x,
   input  logic signed [bpc_pkg::CW-1:0] req_point_y,
   input  logic signed [bpc_pkg::CW-1:0] req_vert_a_x,
   input  logic signed [bpc_pkg::CW-1:0] req_vert_a_y,
   input  logic signed [bpc_pkg::CW-1:0] req_vert_b_x,
   input  logic signed [bpc_pkg::CW-1:0] req_vert_b_y,
   input  logic signed [bpc_pkg::CW-1:0] req_vert_c_x,
   input  logic signed [bpc_pkg::CW-1:0] req_vert_c_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [bpc_pkg::WW-1:0] rsp_alpha_weight,
   output logic signed [bpc_pkg::WW-1:0] rsp_beta_weight,
   output logic signed [bpc_pkg::WW-1:0] rsp_gamma_weight,
   output logic                          rsp_degenerate,
   output logic                          rsp_inside_res,
   output logic                          rsp_on_edge,
   output logic                          rsp_on_vertex,
   output logic                          rsp_saturated,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [bpc_pkg::TW-1:0]        csr_wdata
);
   import bpc_pkg::*;

   logic en;
   logic [TW-1:0] threshold_ff;
   logic [ZW-1:0] tolerance_ff;
   logic f_valid, d_valid;
   logic [MW-1:0] mag_d, mag_b, mag_g;
   logic [QW-1:0] quo_b, quo_g;
   side_type f_side, d_side;

   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         tolerance_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_TOLERANCE: tolerance_ff <= csr_wdata[ZW-1:0];
            default: ;
         endcase
      end
   end

   bpc_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .px(req_point_x), .py(req_point_y), .ax(req_vert_a_x), .ay(req_vert_a_y),
      .bx(req_vert_b_x), .by(req_vert_b_y), .cx(req_vert_c_x), .cy(req_vert_c_y),
      .out_valid(f_valid), .mag_d(mag_d), .mag_b(mag_b), .mag_g(mag_g), .side(f_side)
   );

   bpc_div u_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(f_valid),
      .den(mag_d), .num_b(mag_b), .num_g(mag_g), .side_in(f_side),
      .out_valid(d_valid), .quo_b(quo_b), .quo_g(quo_g), .side_out(d_side)
   );

   bpc_back u_back (
      .clock(clock), .reset(reset), .en(en), .in_valid(d_valid),
      .quo_b(quo_b), .quo_g(quo_g), .side(d_side),
      .threshold(threshold_ff), .tolerance(tolerance_ff),
      .out_valid(rsp_valid), .alpha(rsp_alpha_weight), .beta(rsp_beta_weight),
      .gamma(rsp_gamma_weight), .degen(rsp_degenerate), .in_tri(rsp_inside_res),
      .edge_hit(rsp_on_edge), .vertex_hit(rsp_on_vertex), .clipped(rsp_saturated)
   );
endmodule

[hw/rtl/bpc_checker.sv]
// port-level checks for the barycentric point classifier, bound to the top level
// depends on bpc_pkg and barycentric_point_classifier
module bpc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [bpc_pkg::WW-1:0] rsp_alpha_weight,
   input logic signed [bpc_pkg::WW-1:0] rsp_beta_weight,
   input logic signed [bpc_pkg::WW-1:0] rsp_gamma_weight,
   input logic                          rsp_degenerate,
   input logic                          rsp_inside_res,
   input logic                          rsp_on_edge,
   input logic                          rsp_on_vertex,
   input logic                          rsp_saturated
);
   import bpc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_degen_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_alpha_weight == '0 && rsp_beta_weight == '0
         && rsp_gamma_weight == '0 && !rsp_inside_res && !rsp_on_edge
         && !rsp_on_vertex && !rsp_saturated)
      else $error("degenerate response with nonzero fields");

   a_edge_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_on_edge |-> rsp_inside_res)
      else $error("edge without inside");

   a_inside_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> !rsp_alpha_weight[WW-1] && !rsp_beta_weight[WW-1]
         && !rsp_gamma_weight[WW-1])
      else $error("inside with negative weight");
endmodule

bind barycentric_point_classifier bpc_checker u_bpc_checker (.*);

[sim/tb_barycentric_point_classifier.sv]
// testbench for barycentric_point_classifier: directed table then random requests,
// every response checked against an in-bench predictor of the barycentric weights
// depends on bpc_pkg and the rtl of barycentric_point_classifier
module tb_barycentric_point_classifier;
   timeunit 1ns;
   timeprecision 1ps;
   import bpc_pkg::*;

   localparam int LATENCY = 56;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [15:0] c [8];
   } point_req_type;

   typedef struct packed {
      logic signed [19:0] wa, wb, wg;
      logic degen, in_tri, edge_f, vert, sat;
   } weights_type;

   typedef struct {
      point_req_type req;
      bit has_fixed;
      weights_type fixed;
   } dir_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, req_ready, rsp_valid;
   logic signed [15:0] req_c [8];
   logic signed [19:0] rsp_alpha_weight, rsp_beta_weight, rsp_gamma_weight;
   logic rsp_degenerate, rsp_inside_res, rsp_on_edge, rsp_on_vertex, rsp_saturated;
   logic csr_we = 0, csr_index = 0;
   logic [31:0] csr_wdata = 0;

   logic [31:0] thresh_q = 0;
   logic [15:0] tol_q = 0;
   weights_type expected_weights [$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   bit recv_hold = 0;
   int mismatches = 0, responses = 0, requests = 0, stall_cycles = 0;
   int idle_cycles = 0;

   always #2 clock = ~clock;

   initial for (int i = 0; i < 8; i++) req_c[i] = 0;

   barycentric_point_classifier dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_c[0]), .req_point_y(req_c[1]),
      .req_vert_a_x(req_c[2]), .req_vert_a_y(req_c[3]),
      .req_vert_b_x(req_c[4]), .req_vert_b_y(req_c[5]),
      .req_vert_c_x(req_c[6]), .req_vert_c_y(req_c[7]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_alpha_weight(rsp_alpha_weight), .rsp_beta_weight(rsp_beta_weight),
      .rsp_gamma_weight(rsp_gamma_weight), .rsp_degenerate(rsp_degenerate),
      .rsp_inside_res(rsp_inside_res), .rsp_on_edge(rsp_on_edge),
      .rsp_on_vertex(rsp_on_vertex), .rsp_saturated(rsp_saturated),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic longint q16_quotient(longint num, longint den);
      longint n, un, ud, q;
      n = num * 65536;
      un = n < 0 ? -n : n;
      ud = den < 0 ? -den : den;
      q = un / ud;
      return ((n < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic longint clip_weight(longint v, ref bit clip);
      if (v > 524287) begin
         clip = 1;
         return 524287;
      end
      if (v < -524288) begin
         clip = 1;
         return -524288;
      end
      return v;
   endfunction

   function automatic bit within_tol(longint v, longint target);
      longint d;
      d = v - target;
      if (d < 0) d = -d;
      return d <= longint'(tol_q);
   endfunction

   function automatic weights_type classify_point(point_req_type r);
      longint v0x, v0y, v1x, v1y, v2x, v2y, d, ud, qa, qb, qg, wa, wb, wg;
      bit clip;
      weights_type o;
      v0x = longint'(r.c[4]) - r.c[2]; v0y = longint'(r.c[5]) - r.c[3];
      v1x = longint'(r.c[6]) - r.c[2]; v1y = longint'(r.c[7]) - r.c[3];
      v2x = longint'(r.c[0]) - r.c[2]; v2y = longint'(r.c[1]) - r.c[3];
      d = v0x * v1y - v0y * v1x;
      ud = d < 0 ? -d : d;
      o = '{default: 0};
      clip = 0;
      if (ud <= 65536 && ud * ud <= longint'(thresh_q)) begin
         o.degen = 1;
         return o;
      end
      qb = q16_quotient(v2x * v1y - v2y * v1x, d);
      qg = q16_quotient(v0x * v2y - v0y * v2x, d);
      qa = 65536 - qb - qg;
      wa = clip_weight(qa, clip);
      wb = clip_weight(qb, clip);
      wg = clip_weight(qg, clip);
      o.wa = 20'(wa); o.wb = 20'(wb); o.wg = 20'(wg); o.sat = clip;
      o.in_tri = wa >= 0 && wb >= 0 && wg >= 0;
      o.edge_f = o.in_tri && (within_tol(wa, 0) || within_tol(wb, 0) || within_tol(wg, 0));
      o.vert = (within_tol(wa, 65536) && within_tol(wb, 0) && within_tol(wg, 0)) ||
               (within_tol(wb, 65536) && within_tol(wa, 0) && within_tol(wg, 0)) ||
               (within_tol(wg, 65536) && within_tol(wa, 0) && within_tol(wb, 0));
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      weights_type e;
      if (!reset && req_valid && req_ready) requests <= requests + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         responses <= responses + 1;
         if (expected_weights.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected response at %0t", $realtime);
         end else begin
            e = expected_weights.pop_front();
            if (rsp_alpha_weight !== e.wa || rsp_beta_weight !== e.wb ||
                rsp_gamma_weight !== e.wg || rsp_degenerate !== e.degen ||
                rsp_inside_res !== e.in_tri || rsp_on_edge !== e.edge_f ||
                rsp_on_vertex !== e.vert || rsp_saturated !== e.sat) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  $write("mismatch: exp %0d %0d %0d d%0b i%0b e%0b v%0b s%0b",
                     e.wa, e.wb, e.wg, e.degen, e.in_tri, e.edge_f, e.vert, e.sat);
                  $display(" got %0d %0d %0d d%0b i%0b e%0b v%0b s%0b",
                     rsp_alpha_weight, rsp_beta_weight, rsp_gamma_weight, rsp_degenerate,
                     rsp_inside_res, rsp_on_edge, rsp_on_vertex, rsp_saturated);
               end
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("barycentric_point_classifier verification failed");
         $finish;
      end
   end

   task automatic send_request(point_req_type r, bit has_fixed, weights_type fixed);
      weights_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      for (int i = 0; i < 8; i++) req_c[i] <= r.c[i];
      req_valid <= 1;
      p = classify_point(r);
      if (has_fixed && p != fixed) begin
         mismatches++;
         if (mismatches <= 10) $display("table row disagrees with predictor");
      end
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_weights.push_back(p);
      @(negedge clock);
   endtask

   task automatic drain_pipeline;
      req_valid <= 0;
      while (expected_weights.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      if (idx == CSR_THRESHOLD) thresh_q = val; else tol_q = val[15:0];
      @(negedge clock);
   endtask

   function automatic point_req_type random_triangle(int mode);
      point_req_type r;
      int span, base;
      for (int i = 0; i < 8; i++) r.c[i] = 16'($urandom);
      if (mode == 1) begin
         // small triangle, point near it
         span = 1 << $urandom_range(2, 10);
         base = $urandom_range(0, 60000) - 30000;
         for (int i = 0; i < 8; i++) r.c[i] = 16'(base + $urandom_range(0, span) - span / 2);
      end else if (mode == 2) begin
         // point on a vertex or edge midpoint
         for (int i = 2; i < 8; i++) r.c[i] = 16'($urandom_range(0, 2000) - 1000);
         case ($urandom_range(3))
            0: begin r.c[0] = r.c[2]; r.c[1] = r.c[3]; end
            1: begin r.c[0] = r.c[4]; r.c[1] = r.c[5]; end
            2: begin r.c[0] = r.c[6]; r.c[1] = r.c[7]; end
            default: begin
               r.c[0] = (r.c[2] + r.c[4]) >>> 1; r.c[1] = (r.c[3] + r.c[5]) >>> 1;
            end
         endcase
      end else if (mode == 3) begin
         // collinear or nearly so
         r.c[6] = r.c[4]; r.c[7] = 16'(r.c[5] + $urandom_range(0, 2));
      end
      return r;
   endfunction

   task automatic random_phase(int count);
      weights_type none;
      none = '{default: 0};
      for (int i = 0; i < count; i++)
         send_request(random_triangle($urandom_range(0, 9) < 6 ? 1 :
                      $urandom_range(0, 3)), 0, none);
   endtask

   dir_row_type table_rows [$];

   function automatic dir_row_type mk(int px, int py, int ax, int ay, int bx, int by,
                                      int cx, int cy, bit hf, weights_type f);
      dir_row_type d;
      d.req.c = '{16'(px), 16'(py), 16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(cx), 16'(cy)};
      d.has_fixed = hf;
      d.fixed = f;
      return d;
   endfunction

   initial begin
      weights_type z, va, vb, vc, nofix;
      z = '{default: 0}; z.degen = 1;
      nofix = '{default: 0};
      va = '{default: 0}; va.wa = 65536; va.in_tri = 1; va.edge_f = 1; va.vert = 1;
      vb = va; vb.wa = 0; vb.wb = 65536;
      vc = va; vc.wa = 0; vc.wg = 65536;
      // all zero: degenerate
      table_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, z));
      // point on each vertex of a unit triangle
      table_rows.push_back(mk(0, 0, 0, 0, 16, 0, 0, 16, 1, va));
      table_rows.push_back(mk(16, 0, 0, 0, 16, 0, 0, 16, 1, vb));
      table_rows.push_back(mk(0, 16, 0, 0, 16, 0, 0, 16, 1, vc));
      // extremes
      table_rows.push_back(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 0, nofix));
      table_rows.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0, nofix));
      table_rows.push_back(mk(32767, -32768, -32768, -32768, -32767, -32768, -32768, -32767, 0, nofix));
      table_rows.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, 1, z));
      // collinear
      table_rows.push_back(mk(5, 5, 0, 0, 10, 10, 20, 20, 1, z));
      // inside, outside, edge
      table_rows.push_back(mk(4, 4, 0, 0, 16, 0, 0, 16, 0, nofix));
      table_rows.push_back(mk(40, 40, 0, 0, 16, 0, 0, 16, 0, nofix));
      table_rows.push_back(mk(8, 0, 0, 0, 16, 0, 0, 16, 0, nofix));
      table_rows.push_back(mk(-16, -16, 0, 0, 16, 0, 0, 16, 0, nofix));
      // tiny triangle, far point: saturation
      table_rows.push_back(mk(32767, 32767, 0, 0, 1, 0, 0, 1, 0, nofix));
      table_rows.push_back(mk(-32768, 32767, 0, 0, 1, 0, 0, 1, 0, nofix));
      // reversed winding
      table_rows.push_back(mk(4, 4, 0, 0, 0, 16, 16, 0, 0, nofix));
      // large determinant, never degenerate
      table_rows.push_back(mk(0, 0, -300, -300, 300, -300, 0, 300, 0, nofix));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].has_fixed,
                                           table_rows[i].fixed);
      drain_pipeline();

      // thresholds and tolerances, extremes included
      write_csr(CSR_THRESHOLD, 32'd300);
      write_csr(CSR_TOLERANCE, 32'd2);
      for (int i = 0; i < 6; i++) send_request(table_rows[i + 9].req, 0, nofix);
      drain_pipeline();

      send_idle_pct = 29; recv_idle_pct = 78;
      write_csr(CSR_THRESHOLD, 32'd0);
      write_csr(CSR_TOLERANCE, 32'd0);
      random_phase(110);
      drain_pipeline();

      send_idle_pct = 78; recv_idle_pct = 29;
      write_csr(CSR_THRESHOLD, 32'hFFFF_FFFF);
      write_csr(CSR_TOLERANCE, 32'h0000_FFFF);
      random_phase(110);
      drain_pipeline();

      // receiver holds off long while requests keep coming
      send_idle_pct = 0; recv_idle_pct = 0;
      write_csr(CSR_THRESHOLD, 32'($urandom_range(0, 5000)));
      write_csr(CSR_TOLERANCE, 32'($urandom_range(0, 600)));
      fork
         begin
            recv_hold = 1;
            repeat (200) @(negedge clock);
            stall_cycles = 200;
            recv_hold = 0;
         end
         random_phase(110);
      join
      drain_pipeline();

      write_csr(CSR_THRESHOLD, $urandom);
      write_csr(CSR_TOLERANCE, 32'($urandom_range(0, 65535)));
      random_phase(110);
      drain_pipeline();

      $display("covered %0d requests, %0d responses, directed table plus random triangles",
               requests, responses);
      $display("csr settings from zero to full scale, backpressure stall of %0d cycles",
               stall_cycles);
      if (mismatches == 0 && expected_weights.size() == 0)
         $display("barycentric_point_classifier verification clean");
      else
         $display("barycentric_point_classifier verification failed");
      $finish;
   end
endmodule
